// ===== hw/rtl/fcfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Four-channel flow detector package
// Shared constants, types and arithmetic helpers for the detector lanes,
// the merging stage and the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package fcfd_pkg;

    localparam int NUM_CH         = 4;
    localparam int AVERAGE_DEPTH  = 10;
    localparam int DECISION_DEPTH = 10;

    localparam int SAMPLE_W = 10;
    localparam int AVG_W    = 9;

    localparam int SP_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int AP_W = (DECISION_DEPTH > 1) ? $clog2(DECISION_DEPTH) : 1;

    localparam logic [SP_W-1:0] SP_LAST = SP_W'(AVERAGE_DEPTH - 1);
    localparam logic [AP_W-1:0] AP_LAST = AP_W'(DECISION_DEPTH - 1);

    localparam logic [AVG_W-1:0] THRESHOLD_RESET = AVG_W'(100);

    localparam int SCALE_NUM  = 500;
    localparam int SCALE_DEN  = 1023;
    localparam int SCALE_PROD_W = SAMPLE_W + AVG_W;

    // Reciprocal of the ring depth, rounded up, exact for every 9-bit value.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH);
    localparam int DIV_PROD_W = AVG_W + RECIP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV,
        ST_ACC,
        ST_SWEEP,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic            scale_en;
        logic            div_en;
        logic            acc_en;
        logic            sweep_clr;
        logic            sweep_en;
        logic [SP_W-1:0] sp;
        logic [AP_W-1:0] ap;
        logic [AP_W-1:0] idx;
    } lane_ctrl_t;

    typedef struct packed {
        logic any_above;
        logic all_above;
    } lane_stat_t;

    // floor(raw * 500 / 1023): the quotient by 1024 is at most one short,
    // and one compare against the remainder fixes it.
    function automatic logic [AVG_W-1:0] scale_reading(input logic [SAMPLE_W-1:0] raw);
        logic [SCALE_PROD_W-1:0] prod;
        logic [AVG_W-1:0]        q_est;
        logic [SAMPLE_W:0]       rem;
        prod  = SCALE_PROD_W'(raw) * SCALE_PROD_W'(SCALE_NUM);
        q_est = prod[SCALE_PROD_W-1:SAMPLE_W];
        rem   = (SAMPLE_W+1)'(prod[SAMPLE_W-1:0]) + (SAMPLE_W+1)'(q_est);
        if (rem >= (SAMPLE_W+1)'(SCALE_DEN)) begin
            q_est = q_est + AVG_W'(1);
        end
        return q_est;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/four_channel_flow_detector.sv =====
// ---------------------------------------------------------------------------
// Four-channel flow detector
// Moving-average start/stop detector over four conductivity channels, one
// lane per channel, with a shared sequencer and an output register.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    tdata: four samples, tuser: milking
//  m_        out        m_tvalid/m_tready    tdata: four averages, tuser: flow
//  cfg_      in         cfg_wen              cfg_wdata: flow threshold
//
// An item passes from acceptance through the scale, divide and accumulate states
// and a sweep over the whole average ring to the result register.
// The next item is accepted while a finished result waits in the output register.
// Reset clears both rings, the running sums and the ring positions at once.
// A stalled result holds the sequencer in its last state until taken.
`default_nettype none

module four_channel_flow_detector (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // sample_ch0, sample_ch1, sample_ch2, sample_ch3
    input  wire logic        s_tuser,   // milking_now
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // average_ch0..average_ch3, then zero fill
    output logic             m_tuser,   // flow_present
    input  wire logic        cfg_wen,
    input  wire logic [8:0]  cfg_wdata
);

    fcfd_pkg::seq_state_t state_reg;
    fcfd_pkg::seq_state_t state_next;
    fcfd_pkg::lane_ctrl_t ctrl;
    fcfd_pkg::lane_stat_t lane_stat [fcfd_pkg::NUM_CH];

    logic [fcfd_pkg::SAMPLE_W-1:0] sample_reg [fcfd_pkg::NUM_CH];
    logic [fcfd_pkg::AVG_W-1:0]    lane_avg   [fcfd_pkg::NUM_CH];
    logic                          milking_reg;
    logic [fcfd_pkg::AVG_W-1:0]    threshold_reg;
    logic [fcfd_pkg::SP_W-1:0]     sp_reg;
    logic [fcfd_pkg::AP_W-1:0]     ap_reg;
    logic [fcfd_pkg::AP_W-1:0]     idx_reg;
    logic                          m_valid_reg;
    logic [39:0]                   m_data_reg;
    logic                          m_flow_reg;
    logic                          flow;
    logic                          out_free;
    logic                          in_accept;

    assign out_free  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fcfd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = fcfd_pkg::ST_SCALE;
                end
            end
            fcfd_pkg::ST_SCALE: state_next = fcfd_pkg::ST_DIV;
            fcfd_pkg::ST_DIV:   state_next = fcfd_pkg::ST_ACC;
            fcfd_pkg::ST_ACC:   state_next = fcfd_pkg::ST_SWEEP;
            fcfd_pkg::ST_SWEEP: begin
                if (idx_reg == fcfd_pkg::AP_LAST) begin
                    state_next = fcfd_pkg::ST_OUT;
                end
            end
            fcfd_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = fcfd_pkg::ST_IDLE;
                end
            end
            default: state_next = fcfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        ctrl.scale_en  = 1'b0;
        ctrl.div_en    = 1'b0;
        ctrl.acc_en    = 1'b0;
        ctrl.sweep_clr = 1'b0;
        ctrl.sweep_en  = 1'b0;
        ctrl.sp        = sp_reg;
        ctrl.ap        = ap_reg;
        ctrl.idx       = idx_reg;
        case (state_reg)
            fcfd_pkg::ST_IDLE:  s_tready       = 1'b1;
            fcfd_pkg::ST_SCALE: ctrl.scale_en  = 1'b1;
            fcfd_pkg::ST_DIV:   ctrl.div_en    = 1'b1;
            fcfd_pkg::ST_ACC: begin
                ctrl.acc_en    = 1'b1;
                ctrl.sweep_clr = 1'b1;
            end
            fcfd_pkg::ST_SWEEP: ctrl.sweep_en  = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
                sample_reg[c] <= s_tdata[c*fcfd_pkg::SAMPLE_W +: fcfd_pkg::SAMPLE_W];
            end
            milking_reg <= s_tuser;
        end
        if (state_reg == fcfd_pkg::ST_OUT && out_free) begin
            m_flow_reg <= flow;
            m_data_reg <= {4'b0000, lane_avg[3], lane_avg[2], lane_avg[1], lane_avg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fcfd_pkg::ST_IDLE;
            threshold_reg <= fcfd_pkg::THRESHOLD_RESET;
            sp_reg        <= '0;
            ap_reg        <= '0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                threshold_reg <= cfg_wdata;
            end
            if (state_reg == fcfd_pkg::ST_ACC) begin
                sp_reg  <= (sp_reg == fcfd_pkg::SP_LAST) ? '0 : sp_reg + fcfd_pkg::SP_W'(1);
                ap_reg  <= (ap_reg == fcfd_pkg::AP_LAST) ? '0 : ap_reg + fcfd_pkg::AP_W'(1);
                idx_reg <= '0;
            end else if (state_reg == fcfd_pkg::ST_SWEEP) begin
                idx_reg <= idx_reg + fcfd_pkg::AP_W'(1);
            end
            if (state_reg == fcfd_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    for (genvar c = 0; c < fcfd_pkg::NUM_CH; c++) begin : g_lane
        fcfd_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .sample    (sample_reg[c]),
            .threshold (threshold_reg),
            .average   (lane_avg[c]),
            .status    (lane_stat[c])
        );
    end

    fcfd_merge u_merge (
        .lane_stat (lane_stat),
        .milking   (milking_reg),
        .flow      (flow)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_flow_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fcfd_lane.sv =====
// ---------------------------------------------------------------------------
// Detector lane
// One channel: scales the reading, keeps the ring of divided samples and the
// running average, keeps the ring of averages and sweeps it for the decision.
// ---------------------------------------------------------------------------
`default_nettype none

module fcfd_lane (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fcfd_pkg::lane_ctrl_t          ctrl,
    input  wire logic [fcfd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [fcfd_pkg::AVG_W-1:0]    threshold,
    output logic      [fcfd_pkg::AVG_W-1:0]    average,
    output fcfd_pkg::lane_stat_t               status
);

    logic [fcfd_pkg::AVG_W-1:0] q_ring_reg   [fcfd_pkg::AVERAGE_DEPTH];
    logic [fcfd_pkg::AVG_W-1:0] avg_ring_reg [fcfd_pkg::DECISION_DEPTH];

    logic [fcfd_pkg::AVG_W-1:0]      scaled_reg;
    logic [fcfd_pkg::AVG_W-1:0]      old_q_reg;
    logic [fcfd_pkg::AVG_W-1:0]      q_reg;
    logic [fcfd_pkg::AVG_W-1:0]      sum_reg;
    logic [fcfd_pkg::AVG_W-1:0]      sum_next;
    logic [fcfd_pkg::AVG_W-1:0]      avg_out_reg;
    logic                            any_reg;
    logic                            all_reg;
    logic [fcfd_pkg::DIV_PROD_W-1:0] div_prod;
    logic                            above;

    assign div_prod = fcfd_pkg::DIV_PROD_W'(scaled_reg)
                    * fcfd_pkg::DIV_PROD_W'(fcfd_pkg::RECIP);
    assign sum_next = sum_reg - old_q_reg + q_reg;
    assign above    = avg_ring_reg[ctrl.idx] > threshold;

    always_ff @(posedge aclk) begin
        if (ctrl.scale_en) begin
            scaled_reg <= fcfd_pkg::scale_reading(sample);
            old_q_reg  <= q_ring_reg[ctrl.sp];
        end
        if (ctrl.div_en) begin
            q_reg <= div_prod[fcfd_pkg::DIV_PROD_W-1:fcfd_pkg::RECIP_SHIFT];
        end
        if (ctrl.acc_en) begin
            avg_out_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fcfd_pkg::AVERAGE_DEPTH; i++) begin
                q_ring_reg[i] <= '0;
            end
            for (int i = 0; i < fcfd_pkg::DECISION_DEPTH; i++) begin
                avg_ring_reg[i] <= '0;
            end
            sum_reg <= '0;
            any_reg <= 1'b0;
            all_reg <= 1'b1;
        end else begin
            if (ctrl.acc_en) begin
                q_ring_reg[ctrl.sp]   <= q_reg;
                avg_ring_reg[ctrl.ap] <= sum_next;
                sum_reg               <= sum_next;
            end
            if (ctrl.sweep_clr) begin
                any_reg <= 1'b0;
                all_reg <= 1'b1;
            end else if (ctrl.sweep_en) begin
                any_reg <= any_reg | above;
                all_reg <= all_reg & above;
            end
        end
    end

    assign average          = avg_out_reg;
    assign status.any_above = any_reg;
    assign status.all_above = all_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fcfd_merge.sv =====
// ---------------------------------------------------------------------------
// Lane merge
// Combines the per-lane findings into the flow decision for the current mode.
// ---------------------------------------------------------------------------
`default_nettype none

module fcfd_merge (
    input  wire fcfd_pkg::lane_stat_t lane_stat [fcfd_pkg::NUM_CH],
    input  wire logic                 milking,
    output logic                      flow
);

    logic any_lane_any;
    logic any_lane_all;

    always_comb begin
        any_lane_any = 1'b0;
        any_lane_all = 1'b0;
        for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
            any_lane_any = any_lane_any | lane_stat[c].any_above;
            any_lane_all = any_lane_all | lane_stat[c].all_above;
        end
        flow = milking ? any_lane_any : any_lane_all;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fcfd_checker.sv =====
// ---------------------------------------------------------------------------
// Flow detector port checker
// Watches the top level's ports for handshake and result-range slips.
// ---------------------------------------------------------------------------
`default_nettype none

module fcfd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_avg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:0] <= 9'd500) && (m_tdata[17:9] <= 9'd500)
                  && (m_tdata[26:18] <= 9'd500) && (m_tdata[35:27] <= 9'd500)
                  && (m_tdata[39:36] == 4'd0))
        else $error("average out of range");

endmodule

bind four_channel_flow_detector fcfd_checker u_fcfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Four-channel flow detector testbench
// Streams conductivity readings into the detector and predicts the moving
// averages and the flow decision for each accepted item. Results are checked
// field by field, in order. Thresholds change between phases, and the sender
// and the receiver idle at random.
// ---------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic                                                milking;
        logic [fcfd_pkg::NUM_CH-1:0][fcfd_pkg::SAMPLE_W-1:0] sample;
    } reading_t;

    typedef struct packed {
        logic                                             flow_present;
        logic [fcfd_pkg::NUM_CH-1:0][fcfd_pkg::AVG_W-1:0] average;
    } flow_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wen = 1'b0;
    logic [8:0]  cfg_wdata = '0;

    reading_t     pending_readings[$];
    flow_result_t awaited_flow_results[$];

    logic [fcfd_pkg::AVG_W-1:0] sample_ring  [fcfd_pkg::AVERAGE_DEPTH][fcfd_pkg::NUM_CH];
    logic [fcfd_pkg::AVG_W-1:0] average_ring [fcfd_pkg::DECISION_DEPTH][fcfd_pkg::NUM_CH];
    int                         sample_pos;
    int                         average_pos;
    logic [fcfd_pkg::AVG_W-1:0] threshold_model;

    int mismatch_count = 0;
    int readings_queued = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int holdoff_left = 0;

    four_channel_flow_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic flow_result_t compute_flow_result(input reading_t r);
        flow_result_t res;
        int           sum;
        logic         any_above;
        logic         lane_all_above;
        for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
            sample_ring[sample_pos][c] = fcfd_pkg::AVG_W'(
                (int'(r.sample[c]) * fcfd_pkg::SCALE_NUM) / fcfd_pkg::SCALE_DEN);
        end
        sample_pos = (sample_pos == fcfd_pkg::AVERAGE_DEPTH - 1) ? 0 : sample_pos + 1;
        for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
            sum = 0;
            for (int i = 0; i < fcfd_pkg::AVERAGE_DEPTH; i++) begin
                sum += int'(sample_ring[i][c]) / fcfd_pkg::AVERAGE_DEPTH;
            end
            average_ring[average_pos][c] = fcfd_pkg::AVG_W'(sum);
            res.average[c] = fcfd_pkg::AVG_W'(sum);
        end
        average_pos = (average_pos == fcfd_pkg::DECISION_DEPTH - 1) ? 0 : average_pos + 1;
        any_above = 1'b0;
        if (r.milking) begin
            for (int i = 0; i < fcfd_pkg::DECISION_DEPTH; i++) begin
                for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
                    if (average_ring[i][c] > threshold_model) begin
                        any_above = 1'b1;
                    end
                end
            end
        end else begin
            for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
                lane_all_above = 1'b1;
                for (int i = 0; i < fcfd_pkg::DECISION_DEPTH; i++) begin
                    if (!(average_ring[i][c] > threshold_model)) begin
                        lane_all_above = 1'b0;
                    end
                end
                if (lane_all_above) begin
                    any_above = 1'b1;
                end
            end
        end
        res.flow_present = any_above;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic queue_reading(input int a, input int b, input int c, input int d,
                                 input logic milking);
        reading_t r;
        r.sample[0] = fcfd_pkg::SAMPLE_W'(a);
        r.sample[1] = fcfd_pkg::SAMPLE_W'(b);
        r.sample[2] = fcfd_pkg::SAMPLE_W'(c);
        r.sample[3] = fcfd_pkg::SAMPLE_W'(d);
        r.milking = milking;
        pending_readings.push_back(r);
        readings_queued++;
    endtask

    task automatic wait_until_idle();
        while (results_seen < readings_queued) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_threshold(input int value);
        wait_until_idle();
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= 9'(value);
        threshold_model = fcfd_pkg::AVG_W'(value);
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Most of each phase is runs of steady levels per channel, long enough for
    // the averages to settle; the rest is short bursts of unrelated readings.
    task automatic queue_random_phase(input int count);
        int level [fcfd_pkg::NUM_CH];
        int jitter [fcfd_pkg::NUM_CH];
        int v [fcfd_pkg::NUM_CH];
        int run_len;
        int made;
        logic milking;
        made = 0;
        while (made < count) begin
            milking = 1'($urandom_range(1));
            if ($urandom_range(99) < 75) begin
                run_len = $urandom_range(10, 40);
                for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
                    level[c] = $urandom_range(1023);
                    jitter[c] = $urandom_range(64);
                end
                for (int k = 0; k < run_len; k++) begin
                    for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
                        v[c] = level[c] + int'($urandom_range(2 * jitter[c])) - jitter[c];
                        if (v[c] < 0) v[c] = 0;
                        if (v[c] > 1023) v[c] = 1023;
                    end
                    if ($urandom_range(99) < 10) milking = ~milking;
                    queue_reading(v[0], v[1], v[2], v[3], milking);
                end
                made += run_len;
            end else begin
                run_len = $urandom_range(1, 5);
                for (int k = 0; k < run_len; k++) begin
                    queue_reading($urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(1023), $urandom_range(1023),
                                  1'($urandom_range(1)));
                end
                made += run_len;
            end
        end
    endtask

    always @(posedge aclk) begin : driver
        reading_t offered;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_readings.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                offered = pending_readings.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= offered.sample;
                s_tuser <= offered.milking;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || holdoff_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin : predictor
        reading_t taken;
        if (aresetn && s_tvalid && s_tready) begin
            taken.sample = s_tdata;
            taken.milking = s_tuser;
            awaited_flow_results.push_back(compute_flow_result(taken));
        end
    end

    always @(posedge aclk) begin : monitor
        flow_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (awaited_flow_results.size() == 0) begin
                report_mismatch("result with no item waiting");
            end else begin
                want = awaited_flow_results.pop_front();
                if (m_tuser !== want.flow_present) begin
                    report_mismatch($sformatf("flow_present expected %0d got %0b",
                                              want.flow_present, m_tuser));
                end
                for (int c = 0; c < fcfd_pkg::NUM_CH; c++) begin
                    if (m_tdata[c*fcfd_pkg::AVG_W +: fcfd_pkg::AVG_W] !== want.average[c]) begin
                        report_mismatch($sformatf("average_ch%0d expected %0d got %0d", c,
                                        want.average[c],
                                        m_tdata[c*fcfd_pkg::AVG_W +: fcfd_pkg::AVG_W]));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < fcfd_pkg::AVERAGE_DEPTH; i++) begin
            for (int c = 0; c < fcfd_pkg::NUM_CH; c++) sample_ring[i][c] = '0;
        end
        for (int i = 0; i < fcfd_pkg::DECISION_DEPTH; i++) begin
            for (int c = 0; c < fcfd_pkg::NUM_CH; c++) average_ring[i][c] = '0;
        end
        sample_pos = 0;
        average_pos = 0;
        threshold_model = fcfd_pkg::THRESHOLD_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Full-scale start from reset: zeros age out and the ring wraps.
        for (int k = 0; k < 12; k++) queue_reading(1023, 1023, 1023, 1023, 1'b0);
        queue_reading(0, 0, 0, 0, 1'b1);
        queue_reading(0, 0, 0, 0, 1'b1);
        queue_reading(0, 1023, 1, 1022, 1'b0);
        queue_reading(1023, 0, 512, 511, 1'b1);
        queue_reading(1, 1022, 0, 1023, 1'b0);
        queue_reading(511, 512, 1023, 0, 1'b1);

        write_threshold(0);
        queue_reading(0, 0, 0, 0, 1'b1);
        queue_reading(0, 0, 0, 0, 1'b0);

        write_threshold(511);
        queue_reading(1023, 1023, 1023, 1023, 1'b1);
        queue_reading(1023, 1023, 1023, 1023, 1'b0);

        write_threshold(500);
        queue_reading(1023, 1023, 1023, 1023, 1'b1);
        queue_reading(1023, 1023, 1023, 1023, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            write_threshold($urandom_range(40, 460));
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 70;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 70;
                end
                default: begin
                    sender_idle_pct = 28;
                    receiver_stall_pct = 28;
                end
            endcase
            queue_random_phase(108);
            if (phase == 0) begin
                @(posedge aclk);
                holdoff_left <= HOLDOFF_CYCLES;
            end
        end

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (awaited_flow_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived",
                                      awaited_flow_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
